FILE: rtl/matrix4x4_transform_unit_defines.svh
// Assertion macros used by the checker file
`ifndef MATRIX4X4_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX4X4_TRANSFORM_UNIT_DEFINES_SVH

// Clocked check, muted while reset is asserted
`define M44_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles
`define M44_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/m44_pkg.sv
package m44_pkg;

  localparam logic [3:0] CMD_WR_HELD = 4'd0;
  localparam logic [3:0] CMD_WR_OPND = 4'd1;
  localparam logic [3:0] CMD_IDENT   = 4'd2;
  localparam logic [3:0] CMD_MUL     = 4'd3;
  localparam logic [3:0] CMD_ADD     = 4'd4;
  localparam logic [3:0] CMD_TRANS   = 4'd5;
  localparam logic [3:0] CMD_XVEC    = 4'd6;
  localparam logic [3:0] CMD_XPNT    = 4'd7;
  localparam logic [3:0] CMD_READ    = 4'd8;

  // Operation kinds as classified by the front end
  localparam logic [3:0] K_NOP     = 4'd0;
  localparam logic [3:0] K_WR_HELD = 4'd1;
  localparam logic [3:0] K_WR_OPND = 4'd2;
  localparam logic [3:0] K_IDENT   = 4'd3;
  localparam logic [3:0] K_MUL     = 4'd4;
  localparam logic [3:0] K_ADD     = 4'd5;
  localparam logic [3:0] K_TRANS   = 4'd6;
  localparam logic [3:0] K_XVEC    = 4'd7;
  localparam logic [3:0] K_XPNT    = 4'd8;
  localparam logic [3:0] K_READ    = 4'd9;

  typedef struct packed {
    logic [3:0]         command;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic               is_mac;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } cmd_t;

endpackage

FILE: rtl/m44_fifo.sv
module m44_fifo import m44_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic [DW-1:0] rd_data,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= !wp_r;
      end
      if (do_rd) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

FILE: rtl/m44_front.sv
module m44_front import m44_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  output logic     in_full,
  input  logic     cmd_pop,
  output cmd_t     cmd,
  output logic     cmd_empty
);

  cmd_t cmd_w;
  logic [3:0] kind;

  always_comb begin
    case (in_data.command)
      CMD_WR_HELD: kind = K_WR_HELD;
      CMD_WR_OPND: kind = K_WR_OPND;
      CMD_IDENT:   kind = K_IDENT;
      CMD_MUL:     kind = K_MUL;
      CMD_ADD:     kind = K_ADD;
      CMD_TRANS:   kind = K_TRANS;
      CMD_XVEC:    kind = K_XVEC;
      CMD_XPNT:    kind = K_XPNT;
      CMD_READ:    kind = K_READ;
      default:     kind = K_NOP;
    endcase
  end

  always_comb begin
    cmd_w.kind       = kind;
    cmd_w.is_mac     = (kind == K_MUL) || (kind == K_XVEC) || (kind == K_XPNT);
    cmd_w.elem_index = in_data.elem_index;
    cmd_w.elem_value = in_data.elem_value;
    cmd_w.vec_x      = in_data.vec_x;
    cmd_w.vec_y      = in_data.vec_y;
    cmd_w.vec_z      = in_data.vec_z;
  end

  m44_fifo #(.DW($bits(cmd_t))) u_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (cmd_w),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

FILE: rtl/m44_exec.sv
module m44_exec import m44_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [1:0]  state_r, state_nxt;
  cmd_t        cur_r;
  logic [5:0]  step_r;
  logic [31:0] held_r [16];
  logic [31:0] opnd_r [16];
  logic [31:0] tmp_r  [16];
  out_item_t   res_r;

  logic               is_mul;
  logic [1:0]         row, col, kk;
  logic [31:0]        held_rd;
  logic signed [31:0] mul_a, mul_b;
  logic               step_last;

  logic signed [63:0] prod_r;
  logic [31:0]        raw_val_r;
  logic               pvalid_r, first_r, last_r, use_raw_r;
  logic [3:0]         dst_r;
  logic [31:0]        acc_r, acc_nxt, term;
  logic signed [63:0] shifted;

  assign is_mul    = (cur_r.kind == K_MUL);
  assign row       = is_mul ? step_r[5:4] : step_r[3:2];
  assign col       = step_r[3:2];
  assign kk        = step_r[1:0];
  assign held_rd   = held_r[{row, kk}];
  assign mul_a     = held_rd;
  assign step_last = is_mul ? (step_r == 6'd63) : (step_r == 6'd11);

  always_comb begin
    if (is_mul) begin
      mul_b = opnd_r[{kk, col}];
    end else begin
      case (kk)
        2'd0:    mul_b = cur_r.vec_x;
        2'd1:    mul_b = cur_r.vec_y;
        2'd2:    mul_b = cur_r.vec_z;
        default: mul_b = 32'sd0;
      endcase
    end
  end

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign res_push = (state_r == S_DONE) && !res_full;
  assign res      = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = cmd.is_mac ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        if (step_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pvalid_r <= (state_r == S_RUN);
    end
  end

  // Issue: one product per cycle into the product register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cur_r  <= cmd;
      step_r <= 6'd0;
    end else if (state_r == S_RUN) begin
      step_r <= step_r + 6'd1;
    end
    prod_r    <= 64'(mul_a) * 64'(mul_b);
    raw_val_r <= (cur_r.kind == K_XPNT) ? held_rd : 32'd0;
    use_raw_r <= !is_mul && (kk == 2'd3);
    first_r   <= (kk == 2'd0);
    last_r    <= (kk == 2'd3);
    dst_r     <= is_mul ? step_r[5:2] : {2'b00, step_r[3:2]};
  end

  // Accumulate: the translation term enters unshifted
  assign shifted = prod_r >>> FRAC_BITS;
  assign term    = use_raw_r ? raw_val_r : shifted[31:0];
  assign acc_nxt = (first_r ? 32'd0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      acc_r <= acc_nxt;
      if (last_r && is_mul) begin
        tmp_r[dst_r] <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !cmd_empty) begin
      res_r <= '0;
      if (cmd.kind == K_READ) begin
        res_r.res_x <= held_r[cmd.elem_index];
      end
    end else if (pvalid_r && last_r && !is_mul) begin
      case (dst_r[1:0])
        2'd0:    res_r.res_x <= acc_nxt;
        2'd1:    res_r.res_y <= acc_nxt;
        default: res_r.res_z <= acc_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        held_r[i] <= (i % 5 == 0) ? ONE : 32'd0;
        opnd_r[i] <= 32'd0;
      end
    end else if (state_r == S_IDLE && !cmd_empty) begin
      case (cmd.kind)
        K_WR_HELD: held_r[cmd.elem_index] <= cmd.elem_value;
        K_WR_OPND: opnd_r[cmd.elem_index] <= cmd.elem_value;
        K_IDENT: begin
          for (int i = 0; i < 16; i++) begin
            held_r[i] <= (i % 5 == 0) ? ONE : 32'd0;
          end
        end
        K_ADD: begin
          for (int i = 0; i < 16; i++) begin
            held_r[i] <= held_r[i] + opnd_r[i];
          end
        end
        K_TRANS: begin
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              held_r[c*4 + r] <= held_r[r*4 + c];
            end
          end
        end
        default: ;
      endcase
    end else if (state_r == S_DONE && is_mul) begin
      // commit the product matrix; repeating while stalled is harmless
      for (int i = 0; i < 16; i++) begin
        held_r[i] <= tmp_r[i];
      end
    end
  end

endmodule

FILE: rtl/matrix4x4_transform_unit.sv
// Channel  | Ports                      | Moves
// ---------+----------------------------+------------------------------------
// input    | in_push, in_full, in_data  | one command item (in_item_t)
// result   | out_pop, out_empty, out_data | one result item (out_item_t)
//
// One item is worked at a time; a 2-deep queue on each side decouples the ends.
// Multiply runs 64 products through the single 32x32 multiplier.
// Transforms take 12 multiplier steps; other commands skip the multiplier.
// Reset restores identity in the held matrix and clears the operand matrix.
// A stalled result side holds three results (two queued, one in the back end)
// before the input queue fills.
module matrix4x4_transform_unit import m44_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_data,
  output logic      out_empty
);

  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_item_t res;

  m44_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  m44_exec #(.FRAC_BITS(FRAC_BITS)) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  m44_fifo #(.DW($bits(out_item_t))) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

endmodule

FILE: rtl/m44_checker.sv
`include "matrix4x4_transform_unit_defines.svh"

module m44_checker import m44_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_pop,
  input logic      out_empty,
  input out_item_t out_data
);

  logic [2:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  // items taken in but whose result is not yet taken out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_r + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  `M44_ASSERT_RST(a_empty_after_reset, clk, !rst_n |=> out_empty, "results after reset")
  `M44_ASSERT(a_hold_stalled, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "stalled result changed")
  `M44_ASSERT(a_no_invented, clk, rst_n, !out_empty |-> (pend_r != 3'd0), "result without item")
  `M44_ASSERT(a_capacity, clk, rst_n, (pend_r >= 3'd5) |-> in_full, "more items held than storage")

endmodule

bind matrix4x4_transform_unit m44_checker u_m44_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_data  (out_data)
);

FILE: tb/matrix4x4_transform_unit_tb.sv
`timescale 1ns / 100ps

module matrix4x4_transform_unit_tb;
  import m44_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int N_RANDOM  = 1500;
  localparam logic [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [3:0] CMD_FIRST_UNKNOWN = 4'd9;
  localparam logic [3:0] CMD_UNKNOWN = 4'd15;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_data;
  logic      in_full;
  logic      out_pop;
  out_item_t out_data;
  logic      out_empty;

  matrix4x4_transform_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  // Predictor state
  logic [31:0] held_q [16];
  logic [31:0] opnd_q [16];

  out_item_t expected_results[$];
  int        n_errors;
  bit        stim_done;
  bit        hold_pop;

  typedef struct {
    in_item_t  item;
    bit        has_expected;
    out_item_t expected;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] fx_product(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    p = p >>> FRAC_BITS;
    return p[31:0];
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) held_q[i] = (i % 5 == 0) ? ONE : '0;
  endfunction

  function automatic out_item_t predict_command(in_item_t it);
    out_item_t   r;
    logic [31:0] tmp [16];
    logic [31:0] vec [3];
    logic [31:0] s;
    r = '0;
    vec[0] = it.vec_x;
    vec[1] = it.vec_y;
    vec[2] = it.vec_z;
    case (it.command)
      CMD_WR_HELD: held_q[it.elem_index] = it.elem_value;
      CMD_WR_OPND: opnd_q[it.elem_index] = it.elem_value;
      CMD_IDENT:   load_identity();
      CMD_MUL: begin
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) begin
            s = '0;
            for (int k = 0; k < 4; k++)
              s += fx_product(held_q[rw*4+k], opnd_q[k*4+c]);
            tmp[rw*4+c] = s;
          end
        held_q = tmp;
      end
      CMD_ADD: for (int k = 0; k < 16; k++) held_q[k] += opnd_q[k];
      CMD_TRANS: begin
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++) tmp[c*4+rw] = held_q[rw*4+c];
        held_q = tmp;
      end
      CMD_XVEC, CMD_XPNT: begin
        for (int rw = 0; rw < 3; rw++) begin
          s = '0;
          for (int k = 0; k < 3; k++) s += fx_product(held_q[rw*4+k], vec[k]);
          if (it.command == CMD_XPNT) s += held_q[rw*4+3];
          if (rw == 0) r.res_x = s;
          else if (rw == 1) r.res_y = s;
          else r.res_z = s;
        end
      end
      CMD_READ: r.res_x = held_q[it.elem_index];
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return MAXV;
      1: return MINV;
      2: return $urandom_range(0, 3) << FRAC_BITS;
      3, 4: return 32'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [3:0] cmd, logic [3:0] idx, logic [31:0] val,
                                         logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it.command    = cmd;
    it.elem_index = idx;
    it.elem_value = val;
    it.vec_x      = x;
    it.vec_y      = y;
    it.vec_z      = z;
    return it;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    int       pick;
    it = make_item('0, 4'($urandom), $urandom, rand_value(), rand_value(), rand_value());
    pick = $urandom_range(0, 99);
    // Mostly writes and transforms; multiply is slow, keep it rarer
    if (pick < 25)      it.command = CMD_WR_HELD;
    else if (pick < 45) it.command = CMD_WR_OPND;
    else if (pick < 49) it.command = CMD_IDENT;
    else if (pick < 55) it.command = CMD_MUL;
    else if (pick < 60) it.command = CMD_ADD;
    else if (pick < 64) it.command = CMD_TRANS;
    else if (pick < 76) it.command = CMD_XVEC;
    else if (pick < 88) it.command = CMD_XPNT;
    else if (pick < 97) it.command = CMD_READ;
    else                it.command = 4'($urandom_range(CMD_FIRST_UNKNOWN, CMD_UNKNOWN));
    if (it.command == CMD_WR_HELD || it.command == CMD_WR_OPND) it.elem_value = rand_value();
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit has_exp, out_item_t ex);
    dir_row_t row;
    row.item         = it;
    row.has_expected = has_exp;
    row.expected     = ex;
    dir_rows.push_back(row);
  endfunction

  function automatic out_item_t res(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    out_item_t r;
    r.res_x = x;
    r.res_y = y;
    r.res_z = z;
    return r;
  endfunction

  function automatic void build_directed();
    // Identity after reset: read the diagonal and an off-diagonal element
    add_row(make_item(CMD_READ, 4'd0, MAXV, MAXV, MAXV, MAXV), 1, res(ONE, 0, 0));
    add_row(make_item(CMD_READ, 4'd15, 0, 0, 0, 0), 1, res(ONE, 0, 0));
    add_row(make_item(CMD_READ, 4'd1, 0, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_XPNT, 4'd0, 0, MAXV, MINV, 32'hffff_ffff), 1,
            res(MAXV, MINV, 32'hffff_ffff));
    add_row(make_item(CMD_WR_HELD, 4'd15, MINV, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_READ, 4'd15, 0, 0, 0, 0), 1, res(MINV, 0, 0));
    add_row(make_item(CMD_WR_HELD, 4'd3, MAXV, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_WR_HELD, 4'd7, MINV, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_XPNT, 4'd0, 0, ONE, ONE, ONE), 0, '0);
    add_row(make_item(CMD_XVEC, 4'd0, 0, MINV, MAXV, MINV), 0, '0);
    add_row(make_item(CMD_WR_OPND, 4'd0, MAXV, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_WR_OPND, 4'd5, MINV, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_WR_OPND, 4'd15, 32'hffff_ffff, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_WR_OPND, 4'd12, ONE, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_MUL, 4'd0, 0, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_READ, 4'd0, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_ADD, 4'd0, 0, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_READ, 4'd15, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_TRANS, 4'd0, 0, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_READ, 4'd12, 0, 0, 0, 0), 0, '0);
    add_row(make_item(CMD_XPNT, 4'hf, MAXV, MAXV, MAXV, MAXV), 0, '0);
    add_row(make_item(CMD_FIRST_UNKNOWN, 4'hf, MAXV, MAXV, MAXV, MAXV), 1, res(0, 0, 0));
    add_row(make_item(CMD_UNKNOWN, 4'hf, MINV, MINV, MINV, MINV), 1, res(0, 0, 0));
    add_row(make_item(CMD_IDENT, 4'd0, 0, 0, 0, 0), 1, res(0, 0, 0));
    add_row(make_item(CMD_READ, 4'd5, 0, 0, 0, 0), 1, res(ONE, 0, 0));
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(in_item_t it, bit has_exp, out_item_t ex);
    out_item_t predicted;
    int        gap;
    gap = gap_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    predicted = predict_command(it);
    if (has_exp && predicted !== ex) begin
      $display("%0t predictor disagrees with table: exp %h got %h", $time, ex, predicted);
      n_errors++;
    end
    expected_results.push_back(has_exp ? ex : predicted);
  endtask

  // Stimulus
  initial begin
    in_item_t it;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    n_errors  = 0;
    load_identity();
    for (int i = 0; i < 16; i++) opnd_q[i] = '0;
    build_directed();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_expected,
                                    dir_rows[i].expected);
    for (int n = 0; n < N_RANDOM; n++) begin
      it = random_command();
      send_item(it, 0, '0);
    end
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random pops, one long hold-off to fill the block
  initial begin
    out_pop  = 1'b0;
    hold_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_pop && expected_results.size() >= 3) begin
        hold_pop = 1'b1;
        out_pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 2) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end
      out_pop <= ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
    end
  end

  // Checker
  always @(posedge clk) begin
    out_item_t ex;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: exp none got %h", $time, out_data);
        n_errors++;
      end else begin
        ex = expected_results.pop_front();
        if (out_data.res_x !== ex.res_x) begin
          $display("%0t res_x: exp %h got %h", $time, ex.res_x, out_data.res_x);
          n_errors++;
        end
        if (out_data.res_y !== ex.res_y) begin
          $display("%0t res_y: exp %h got %h", $time, ex.res_y, out_data.res_y);
          n_errors++;
        end
        if (out_data.res_z !== ex.res_z) begin
          $display("%0t res_z: exp %h got %h", $time, ex.res_z, out_data.res_z);
          n_errors++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
